FILE: sv/cgp_pkg.sv
// Shared types, constants and lane arithmetic for the clamped gradient predictor.
`default_nettype none

package cgp_pkg;

    localparam int CFG_W              = 13;
    localparam int PIX_W              = 32;
    localparam int LANE_W             = 8;
    localparam int LANES              = PIX_W / LANE_W;
    localparam int DEF_MAX_ROW_PIXELS = 4096;
    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = CFG_W'(4096);

    typedef struct packed {
        logic col0;
        logic first;
    } t_pos_info;

    function automatic logic [LANE_W-1:0] lane_predict(
        input logic [LANE_W-1:0] a,
        input logic [LANE_W-1:0] b,
        input logic [LANE_W-1:0] c
    );
        logic signed [LANE_W+1:0] p;
        logic [LANE_W-1:0]        lo;
        logic [LANE_W-1:0]        hi;
        p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
        lo = a;
        hi = a;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        if (b > hi) hi = b;
        if (c > hi) hi = c;
        if (p < $signed({2'b00, lo})) begin
            return lo;
        end else if (p > $signed({2'b00, hi})) begin
            return hi;
        end
        return p[LANE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/clamped_gradient_pixel_predictor_unit.sv
// Clamped gradient pixel predictor: one predicted RGBA8 word per input pixel.
//
// Pixels enter in raster order, one per clock unless the output stalls; each prediction
// passes the stage-1 register and a single output register. The line store is one
// read-first RAM port: each pixel reads the entry above it and overwrites it in the same
// cycle, which sets the rate at one pixel a clock. The row store needs no clearing after
// reset; the first row of a frame never uses it. Write row_width only while the block is
// idle. A width of 0 acts as 1, and widths above MAX_ROW_PIXELS act as MAX_ROW_PIXELS.
`default_nettype none

module clamped_gradient_pixel_predictor_unit
    import cgp_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = DEF_MAX_ROW_PIXELS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_row_width,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic             i_frame_start,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [PIX_W-1:0] o_prediction
);

    localparam int CW = $clog2(MAX_ROW_PIXELS);

    logic             acc;
    logic             out_free;
    logic             s1_fire;
    logic [CW-1:0]    addr;
    t_pos_info        info;
    logic [PIX_W-1:0] rd_data;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] upleft;
    logic [PIX_W-1:0] pred;

    logic             r_s1_vld;
    logic [PIX_W-1:0] r_s1_pix;
    t_pos_info        r_s1_info;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upleft;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_pred;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || !i_stall;
    assign s1_fire     = r_s1_vld && out_free;
    assign o_stall     = r_s1_vld && !out_free;
    assign acc         = i_valid && !o_stall;

    cgp_pos #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_pos (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_row_width (i_cfg_row_width),
        .i_acc           (acc),
        .i_frame_start   (i_frame_start),
        .o_addr          (addr),
        .o_info          (info)
    );

    cgp_line_ram #(
        .DEPTH (MAX_ROW_PIXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_addr  (addr),
        .i_wdata (i_pixel),
        .o_rdata (rd_data)
    );

    assign up     = r_s1_info.first ? '0 : rd_data;
    assign left   = r_s1_info.col0 ? '0 : r_left;
    assign upleft = (r_s1_info.col0 || r_s1_info.first) ? '0 : r_upleft;

    cgp_pred u_pred (
        .i_left   (left),
        .i_up     (up),
        .i_upleft (upleft),
        .o_pred   (pred)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_left    <= '0;
            r_upleft  <= '0;
        end else begin
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
                r_left    <= r_s1_pix;
                r_upleft  <= up;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= i_pixel;
            r_s1_info <= info;
        end
        if (s1_fire) begin
            r_out_pred <= pred;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_prediction = r_out_pred;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_vld)
        else $error("input stalled with empty stage");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_fire) |=> r_s1_vld)
        else $error("blocked item lost from stage");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_vld)
        else $error("item left stage without reaching output");

    a_frame_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_frame_start) |=> (r_s1_info.first && r_s1_info.col0))
        else $error("frame start did not reset position");

endmodule

`default_nettype wire

FILE: sv/cgp_line_ram.sv
// Read-first single-port line store holding the previous image row.
`default_nettype none

module cgp_line_ram
    import cgp_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ROW_PIXELS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [PIX_W-1:0] i_wdata,
    output logic      [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // old entry comes out, current pixel goes in
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/cgp_pos.sv
// Row width register and raster position tracker.
`default_nettype none

module cgp_pos
    import cgp_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = DEF_MAX_ROW_PIXELS,
    localparam int CW            = $clog2(MAX_ROW_PIXELS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_row_width,
    input  wire logic             i_acc,
    input  wire logic             i_frame_start,
    output logic      [CW-1:0]    o_addr,
    output t_pos_info             o_info
);

    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    logic [CFG_W-1:0] r_row_width;
    logic [CW-1:0]    r_col;
    logic             r_first;

    logic [WW-1:0] w_cfg;
    logic [WW-1:0] eff_w;
    logic [CW-1:0] col_eff;
    logic          first_eff;
    logic [WW-1:0] col_inc;
    logic [CW-1:0] n_col;
    logic          n_first;

    always_comb begin
        w_cfg = WW'(r_row_width);
        if (w_cfg == '0) begin
            eff_w = WW'(1);
        end else if (w_cfg > WW'(MAX_ROW_PIXELS)) begin
            eff_w = WW'(MAX_ROW_PIXELS);
        end else begin
            eff_w = w_cfg;
        end

        if (i_frame_start) begin
            col_eff   = '0;
            first_eff = 1'b1;
        end else if (WW'(r_col) >= eff_w) begin
            col_eff   = '0;
            first_eff = 1'b0;
        end else begin
            col_eff   = r_col;
            first_eff = r_first;
        end

        col_inc = WW'(col_eff) + WW'(1);
        if (col_inc >= eff_w) begin
            n_col   = '0;
            n_first = 1'b0;
        end else begin
            n_col   = col_inc[CW-1:0];
            n_first = first_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
            r_col       <= '0;
            r_first     <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_row_width <= i_cfg_row_width;
            end
            if (i_acc) begin
                r_col   <= n_col;
                r_first <= n_first;
            end
        end
    end

    assign o_addr       = col_eff;
    assign o_info.col0  = (col_eff == '0);
    assign o_info.first = first_eff;

endmodule

`default_nettype wire

FILE: sv/cgp_pred.sv
// Four-lane clamped gradient prediction.
`default_nettype none

module cgp_pred
    import cgp_pkg::*;
(
    input  wire logic [PIX_W-1:0] i_left,
    input  wire logic [PIX_W-1:0] i_up,
    input  wire logic [PIX_W-1:0] i_upleft,
    output logic      [PIX_W-1:0] o_pred
);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        assign o_pred[g*LANE_W +: LANE_W] = lane_predict(i_left[g*LANE_W +: LANE_W],
                                                         i_up[g*LANE_W +: LANE_W],
                                                         i_upleft[g*LANE_W +: LANE_W]);
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the clamped gradient predictor: directed table, random phases.
module tb;
    import cgp_pkg::*;

    localparam int LINE_MAX = DEF_MAX_ROW_PIXELS;
    localparam int N_DIR    = 22;
    localparam int N_PHASE  = 12;

    typedef struct packed {
        logic             wr;
        logic [CFG_W-1:0] width;
        logic             fs;
        logic [PIX_W-1:0] pix;
        logic             known;
        logic [PIX_W-1:0] res;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_row_width;
    logic             i_valid;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel;
    logic             i_frame_start;
    logic             o_valid;
    logic             i_stall;
    logic [PIX_W-1:0] o_prediction;

    // predictor state
    logic [PIX_W-1:0] line_q [0:LINE_MAX-1];
    bit               line_ok [0:LINE_MAX-1];
    logic [PIX_W-1:0] left_q;
    logic [PIX_W-1:0] upleft_q;
    int               pos_col;
    bit               pos_first_row;
    logic [CFG_W-1:0] width_reg;

    logic [PIX_W-1:0] predictions_due [$];
    logic [PIX_W-1:0] want_pred;
    int               mismatch_count;
    int               snd_idle_pct;
    int               rcv_stall_pct;

    t_dir_row dir_tab [0:N_DIR-1] = '{
        '{1'b0, 13'd0,    1'b0, 32'hFFFFFFFF, 1'b1, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'h00000000, 1'b1, 32'hFFFFFFFF},
        '{1'b0, 13'd0,    1'b0, 32'h12345678, 1'b1, 32'h00000000},
        '{1'b0, 13'd0,    1'b1, 32'hA5A5A5A5, 1'b1, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'h5A5A5A5A, 1'b1, 32'hA5A5A5A5},
        '{1'b1, 13'd2,    1'b0, 32'h01020304, 1'b0, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'h80FF007F, 1'b0, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'hFF00FF00, 1'b0, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'h00FF00FF, 1'b0, 32'h00000000},
        '{1'b1, 13'd0,    1'b0, 32'h7F807F80, 1'b0, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'h11223344, 1'b0, 32'h00000000},
        '{1'b0, 13'd0,    1'b1, 32'hC0C0C0C0, 1'b1, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'h3F3F3F3F, 1'b1, 32'hC0C0C0C0},
        '{1'b1, 13'd3,    1'b1, 32'hF0101080, 1'b1, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'h10F01080, 1'b1, 32'hF0101080},
        '{1'b0, 13'd0,    1'b0, 32'h00000000, 1'b1, 32'h10F01080},
        '{1'b0, 13'd0,    1'b0, 32'h10F0FF00, 1'b0, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'hF010F080, 1'b0, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'hFFFFFFFF, 1'b0, 32'h00000000},
        '{1'b1, 13'd8191, 1'b1, 32'h0000FFFF, 1'b1, 32'h00000000},
        '{1'b0, 13'd0,    1'b0, 32'hFFFF0000, 1'b1, 32'h0000FFFF},
        '{1'b1, 13'd4096, 1'b0, 32'h13579BDF, 1'b1, 32'hFFFF0000}
    };

    int ph_width [0:N_PHASE-1] = '{5, 1, 0, 2, 8191, 7, 16, 3, 4096, 13, 31, 4095};
    int ph_items [0:N_PHASE-1] = '{130, 80, 60, 120, 60, 150, 150, 150, 60, 150, 80, 60};
    int ph_mode  [0:N_PHASE-1] = '{0, 1, 2, 3, 0, 1, 2, 3, 1, 0, 2, 3};

    clamped_gradient_pixel_predictor_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_row_width (i_cfg_row_width),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel         (i_pixel),
        .i_frame_start   (i_frame_start),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_prediction    (o_prediction)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[clamped_gradient_pixel_predictor_unit] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch: got %08h, expected %08h", $realtime, what, got, want);
    endtask

    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    // true when a pixel without frame start would read a line entry never written
    function automatic bit reads_unwritten();
        int c;
        bit f;
        c = pos_col;
        f = pos_first_row;
        if (c >= eff_width()) begin
            c = 0;
            f = 1'b0;
        end
        return !f && !line_ok[c];
    endfunction

    function automatic logic [PIX_W-1:0] predict_pixel(input logic [PIX_W-1:0] pix,
                                                       input logic fs);
        int               w;
        int               la, lb, lc, lo, hi, s;
        logic [PIX_W-1:0] l, u, ul, p;
        w = eff_width();
        if (fs) begin
            pos_col = 0;
            pos_first_row = 1'b1;
        end else if (pos_col >= w) begin
            pos_col = 0;
            pos_first_row = 1'b0;
        end
        l  = (pos_col == 0) ? '0 : left_q;
        u  = pos_first_row ? '0 : line_q[pos_col];
        ul = (pos_col == 0 || pos_first_row) ? '0 : upleft_q;
        for (int k = 0; k < LANES; k++) begin
            la = int'(l[k*LANE_W +: LANE_W]);
            lb = int'(u[k*LANE_W +: LANE_W]);
            lc = int'(ul[k*LANE_W +: LANE_W]);
            lo = la;
            hi = la;
            if (lb < lo) lo = lb;
            if (lc < lo) lo = lc;
            if (lb > hi) hi = lb;
            if (lc > hi) hi = lc;
            s = la + lb - lc;
            if (s < lo) s = lo;
            else if (s > hi) s = hi;
            p[k*LANE_W +: LANE_W] = s[LANE_W-1:0];
        end
        upleft_q = u;
        left_q = pix;
        line_q[pos_col] = pix;
        line_ok[pos_col] = 1'b1;
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_first_row = 1'b0;
        end
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] v;
        for (int k = 0; k < LANES; k++) begin
            case ($urandom_range(3))
                0: v[k*LANE_W +: LANE_W] = LANE_W'($urandom);
                1: v[k*LANE_W +: LANE_W] = '0;
                2: v[k*LANE_W +: LANE_W] = '1;
                default: v[k*LANE_W +: LANE_W] =
                    left_q[k*LANE_W +: LANE_W] + LANE_W'($urandom_range(6)) - LANE_W'(3);
            endcase
        end
        return v;
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                              output logic [PIX_W-1:0] pred);
        if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_valid       <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_stall);
        pred = predict_pixel(pix, fs);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (predictions_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_row_width(input logic [CFG_W-1:0] w);
        wait_drained();
        i_cfg_valid     <= 1'b1;
        i_cfg_row_width <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        width_reg = w;
    endtask

    // receiver: random stall and result check
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (predictions_due.size() == 0) begin
                report_mismatch("unexpected item", o_prediction, '0);
            end else begin
                want_pred = predictions_due.pop_front();
                if (o_prediction !== want_pred) begin
                    report_mismatch("prediction", o_prediction, want_pred);
                end
            end
        end
    end

    initial begin
        logic [PIX_W-1:0] pred;
        logic [PIX_W-1:0] pix;
        logic             fs;
        int               fs_pct;

        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_pixel         <= '0;
        i_frame_start   <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_row_width <= '0;
        i_stall         <= 1'b0;
        mismatch_count  = 0;
        snd_idle_pct    = 0;
        rcv_stall_pct   = 0;
        left_q          = '0;
        upleft_q        = '0;
        pos_col         = 0;
        pos_first_row   = 1'b1;
        width_reg       = ROW_WIDTH_RESET;
        for (int k = 0; k < LINE_MAX; k++) begin
            line_q[k]  = '0;
            line_ok[k] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_tab[r].wr) write_row_width(dir_tab[r].width);
            push_pixel(dir_tab[r].pix, dir_tab[r].fs, pred);
            predictions_due.push_back(dir_tab[r].known ? dir_tab[r].res : pred);
        end

        for (int ph = 0; ph < N_PHASE; ph++) begin
            write_row_width(CFG_W'(ph_width[ph]));
            case (ph_mode[ph])
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 53; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 53; end
                default: begin snd_idle_pct = 6; rcv_stall_pct = 6; end
            endcase
            fs_pct = (eff_width() > 64) ? 0 : 3;
            for (int n = 0; n < ph_items[ph]; n++) begin
                pix = rand_pixel();
                fs  = ($urandom_range(99) < fs_pct) || reads_unwritten();
                push_pixel(pix, fs, pred);
                predictions_due.push_back(pred);
            end
        end

        snd_idle_pct = 0;
        wait_drained();
        rcv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && predictions_due.size() == 0) begin
            $display("[clamped_gradient_pixel_predictor_unit] OK");
        end else begin
            $display("[clamped_gradient_pixel_predictor_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/cgp_pkg.sv
sv/cgp_line_ram.sv
sv/cgp_pos.sv
sv/cgp_pred.sv
sv/clamped_gradient_pixel_predictor_unit.sv
tb/tb.sv
